[design/cda_pkg.sv]
// Shared types and constants of the crowd density alpha block.
package cda_pkg;

    localparam int MAX_UNITS   = 64;
    localparam int IDX_W       = $clog2(MAX_UNITS);
    localparam int CNT_W       = $clog2(MAX_UNITS + 1);
    localparam int ADDR_W      = IDX_W + 1;
    localparam int STORE_DEPTH = 2 ** ADDR_W;
    localparam int POS_W       = 32;
    localparam int JOB_Q_DEPTH = 2;

    localparam int RADIUS_W  = 33;
    localparam int LIMIT_W   = 4;
    localparam int ALPHA_W   = 8;
    localparam int CFG_W     = 33;
    localparam int CFG_IDX_W = 2;

    localparam logic [RADIUS_W-1:0] RADIUS_SQ_RST = 33'd262144;
    localparam logic [LIMIT_W-1:0]  LIMIT_RST     = 4'd4;
    localparam logic [ALPHA_W-1:0]  DIM_ALPHA_RST = 8'd76;
    localparam logic [ALPHA_W-1:0]  OPAQUE_ALPHA  = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RADIUS_SQ   = 2'd0,
        CFG_CROWD_LIMIT = 2'd1,
        CFG_DIM_ALPHA   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
    } t_pos;

    typedef struct packed {
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [5:0] unit_index;
        logic [3:0] neighbor_count;
        logic [7:0] alpha;
        logic       overflow;
        logic       last_result;
    } t_out_item;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] n;
        logic             overflow;
    } t_job;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_release;

endpackage

[design/cda_ram.sv]
// Generic simple dual-port RAM with registered read data.
module cda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/cda_front.sv]
// Front end: loads unit positions into the free store bank and queues frame jobs.
module cda_front
    import cda_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_in_item          i_in_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_wr_en,
    output logic [ADDR_W-1:0] o_wr_addr,
    output t_pos              o_wr_data,
    output t_job              o_job,
    output logic              o_job_push,
    input  logic              i_job_full,
    input  t_release          i_rel
);

    logic [CNT_W-1:0] r_unit_count;
    logic             r_overflow;
    logic             r_bank;
    logic [1:0]       r_busy;
    logic             full;
    logic             accept;

    assign full       = (r_unit_count == CNT_W'(MAX_UNITS));
    assign o_in_stall = r_busy[r_bank] || i_job_full;
    assign accept     = i_in_valid && !o_in_stall;

    assign o_wr_en     = accept && !full;
    assign o_wr_addr   = {r_bank, r_unit_count[IDX_W-1:0]};
    assign o_wr_data.x = i_in_data.pos_x;
    assign o_wr_data.y = i_in_data.pos_y;

    assign o_job_push     = accept && i_in_data.frame_end;
    assign o_job.bank     = r_bank;
    assign o_job.n        = full ? r_unit_count : r_unit_count + CNT_W'(1);
    assign o_job.overflow = r_overflow || full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_count <= '0;
            r_overflow   <= 1'b0;
            r_bank       <= 1'b0;
            r_busy       <= '0;
        end else begin
            if (i_rel.valid) begin
                r_busy[i_rel.bank] <= 1'b0;
            end
            if (accept) begin
                if (i_in_data.frame_end) begin
                    r_unit_count   <= '0;
                    r_overflow     <= 1'b0;
                    r_bank         <= ~r_bank;
                    r_busy[r_bank] <= 1'b1;
                end else if (full) begin
                    r_overflow <= 1'b1;
                end else begin
                    r_unit_count <= r_unit_count + CNT_W'(1);
                end
            end
        end
    end

    a_rel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rel.valid |-> r_busy[i_rel.bank])
        else $error("bank released that was not in use");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_unit_count <= CNT_W'(MAX_UNITS))
        else $error("unit count beyond capacity");

endmodule

[design/cda_job_q.sv]
// Short queue of frame jobs between the front end and the neighbor counter.
module cda_job_q
    import cda_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_data
);

    localparam int JQ_AW = $clog2(JOB_Q_DEPTH);

    t_job             r_mem [JOB_Q_DEPTH];
    logic [JQ_AW-1:0] r_wp;
    logic [JQ_AW-1:0] r_rp;
    logic [JQ_AW:0]   r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == (JQ_AW + 1)'(JOB_Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + JQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + JQ_AW'(1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (JQ_AW + 1)'(1);
                2'b01:   r_cnt <= r_cnt - (JQ_AW + 1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[design/cda_back.sv]
// Back end: counts neighbors of each stored unit and emits one result item per unit.
module cda_back
    import cda_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  t_job                 i_job,
    input  logic                 i_job_valid,
    output logic                 o_job_pop,
    output logic [ADDR_W-1:0]    o_rd_addr,
    input  t_pos                 i_rd_data,
    output t_out_item            o_out_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_release             o_rel
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_RDI,
        S_WAITI,
        S_SWEEP,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [RADIUS_W-1:0] r_radius_sq;
    logic [LIMIT_W-1:0]  r_limit;
    logic [ALPHA_W-1:0]  r_dim_alpha;
    logic                r_bank;
    logic [CNT_W-1:0]    r_n;
    logic                r_ovf;
    logic [IDX_W-1:0]    r_i;
    logic [IDX_W-1:0]    r_j;
    t_pos                r_pos_i;
    logic [LIMIT_W-1:0]  r_count;
    logic                r_rd_vld;
    logic                r_rd_skip;
    logic                r_s1_vld;
    logic                r_s2_vld;
    logic [15:0]         r_ax;
    logic [15:0]         r_ay;
    logic [31:0]         r_sqx;
    logic [31:0]         r_sqy;
    logic                r_out_valid;
    t_out_item           r_out;
    t_release            r_rel;

    logic signed [16:0]  dx;
    logic signed [16:0]  dy;
    logic [32:0]         sq_sum;
    logic                hit;
    logic                out_free;
    logic                last;
    logic                crowded;

    assign o_job_pop = (r_state == S_IDLE) && i_job_valid;
    assign o_rd_addr = (r_state == S_SWEEP) ? {r_bank, r_j} : {r_bank, r_i};

    assign dx     = 17'(r_pos_i.x) - 17'(i_rd_data.x);
    assign dy     = 17'(r_pos_i.y) - 17'(i_rd_data.y);
    assign sq_sum = {1'b0, r_sqx} + {1'b0, r_sqy};
    assign hit    = (sq_sum <= r_radius_sq);

    assign out_free = !r_out_valid || !i_out_stall;
    assign last     = (CNT_W'(r_i) == r_n - CNT_W'(1));
    assign crowded  = (r_n != CNT_W'(1)) && (r_count >= r_limit);

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_rel       = r_rel;

    always_ff @(posedge i_clk) begin
        if (r_rd_vld) begin
            r_ax <= 16'(dx[16] ? -dx : dx);
            r_ay <= 16'(dy[16] ? -dy : dy);
        end
        if (r_s1_vld) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius_sq <= RADIUS_SQ_RST;
            r_limit     <= LIMIT_RST;
            r_dim_alpha <= DIM_ALPHA_RST;
            r_rd_vld    <= 1'b0;
            r_s1_vld    <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_out_valid <= 1'b0;
            r_rel       <= '0;
        end else begin
            r_rel.valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS_SQ:   r_radius_sq <= i_cfg_wdata[RADIUS_W-1:0];
                    CFG_CROWD_LIMIT: r_limit     <= i_cfg_wdata[LIMIT_W-1:0];
                    CFG_DIM_ALPHA:   r_dim_alpha <= i_cfg_wdata[ALPHA_W-1:0];
                    default: ;
                endcase
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            r_rd_vld  <= (r_state == S_SWEEP);
            r_rd_skip <= (r_j == r_i);
            r_s1_vld  <= r_rd_vld && !r_rd_skip;
            r_s2_vld  <= r_s1_vld;
            if (r_s2_vld && hit && (r_count < r_limit)) begin
                r_count <= r_count + LIMIT_W'(1);
            end

            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_bank  <= i_job.bank;
                        r_n     <= i_job.n;
                        r_ovf   <= i_job.overflow;
                        r_i     <= '0;
                        r_state <= S_RDI;
                    end
                end
                S_RDI: begin
                    r_count <= '0;
                    r_state <= S_WAITI;
                end
                S_WAITI: begin
                    r_pos_i <= i_rd_data;
                    r_j     <= '0;
                    r_state <= S_SWEEP;
                end
                S_SWEEP: begin
                    if (CNT_W'(r_j) == r_n - CNT_W'(1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_j <= r_j + IDX_W'(1);
                    end
                end
                S_DRAIN: begin
                    if (!r_rd_vld && !r_s1_vld && !r_s2_vld) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid          <= 1'b1;
                        r_out.unit_index     <= 6'(r_i);
                        r_out.neighbor_count <= r_count;
                        r_out.alpha          <= crowded ? r_dim_alpha : OPAQUE_ALPHA;
                        r_out.overflow       <= r_ovf;
                        r_out.last_result    <= last;
                        if (last) begin
                            r_rel.valid <= 1'b1;
                            r_rel.bank  <= r_bank;
                            r_state     <= S_IDLE;
                        end else begin
                            r_i     <= r_i + IDX_W'(1);
                            r_state <= S_RDI;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_emit_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (!r_rd_vld && !r_s1_vld && !r_s2_vld))
        else $error("result taken before the distance pipeline drained");

    a_rel_after_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rel.valid |-> $past(r_state == S_EMIT))
        else $error("bank released outside of result emission");

    a_sweep_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (CNT_W'(r_j) < r_n))
        else $error("sweep index beyond the frame");

endmodule

[design/crowd_density_alpha.sv]
// Top level of the crowd density alpha block.
// Loading takes one item per cycle unless stalled; one store bank fills while the other is counted.
// For each unit of a frame the back end reads its position, sweeps the frame's stored positions
// over the single read port through the distance pipeline, drains it and then emits the result.
// Reset is synchronous and active low; it clears control state and loads register defaults.
// The position store is not cleared and needs no clearing pass.
module crowd_density_alpha
    import cda_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_wdata,
    input  t_in_item             i_in_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    output t_out_item            o_out_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall
);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_pos              wr_data;
    logic [ADDR_W-1:0] rd_addr;
    t_pos              rd_data;
    t_job              push_job;
    logic              job_push;
    logic              job_full;
    t_job              head_job;
    logic              job_valid;
    logic              job_pop;
    t_release          rel;

    cda_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr_data  (wr_data),
        .o_job      (push_job),
        .o_job_push (job_push),
        .i_job_full (job_full),
        .i_rel      (rel)
    );

    cda_ram #(
        .WIDTH (POS_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    cda_job_q u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (push_job),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_valid (job_valid),
        .o_data  (head_job)
    );

    cda_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_job       (head_job),
        .i_job_valid (job_valid),
        .o_job_pop   (job_pop),
        .o_rd_addr   (rd_addr),
        .i_rd_data   (rd_data),
        .o_out_data  (o_out_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rel       (rel)
    );

endmodule
